>>> src/vlc_pkg.sv
// shared types and constants of the voltage loop 2p2z compensator
package vlc_pkg;

  // input item of the compensator
  typedef struct packed {
    logic        operation;
    logic [9:0]  sample_a;
    logic [9:0]  sample_b;
    logic [11:0] target;
    logic [14:0] period_command;
    logic [10:0] gain_factor;
  } vlc_in_t;

  // result item of the compensator
  typedef struct packed {
    logic [14:0]        drive;
    logic signed [7:0]  limited_error;
    logic [11:0]        voltage_sum;
  } vlc_out_t;

  // operation codes
  localparam logic OP_RUN     = 1'b0;
  localparam logic OP_PRELOAD = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM0 = 3'd0,
    CFG_NUM1 = 3'd1,
    CFG_NUM2 = 3'd2,
    CFG_DEN1 = 3'd3,
    CFG_DEN2 = 3'd4
  } vlc_cfg_e;

  // coefficient reset values
  localparam logic signed [31:0] NUM0_RST = -32'sd63962;
  localparam logic signed [31:0] NUM1_RST = 32'sd79458;
  localparam logic signed [31:0] NUM2_RST = -32'sd22651;
  localparam logic signed [15:0] DEN1_RST = 16'sd8435;
  localparam logic signed [15:0] DEN2_RST = -16'sd243;

  // gain schedule
  localparam logic [31:0] SCHED_MUL = 32'h0000_044D;
  localparam logic [10:0] SCHED_OFS = 11'd74;
  localparam logic [7:0]  SCHED_LO  = 8'd44;
  localparam logic [7:0]  SCHED_HI  = 8'd128;

  // error slew limit and clamp
  localparam logic signed [14:0] SLEW_TRIP = 15'sd100;
  localparam logic signed [13:0] SLEW_STEP = 14'sd50;
  localparam logic signed [13:0] ERR_LIMIT = 14'sd100;

  // drive clamp
  localparam logic signed [31:0] DRIVE_MAX = 32'sd25000;
  localparam logic signed [31:0] DRIVE_MIN = 32'sd2600;

endpackage

>>> src/vlc_in_if.sv
// input channel of the compensator: valid, ready and the input item
interface vlc_in_if;
  logic             valid;
  logic             ready;
  vlc_pkg::vlc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/vlc_out_if.sv
// output channel of the compensator: valid, ready and the result item
interface vlc_out_if;
  logic              valid;
  logic              ready;
  vlc_pkg::vlc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/voltage_loop_2p2z_compensator_unit.sv
// voltage loop two-pole two-zero compensator with one shared multiplier
//
// in_i carries one item: two adc samples, target, previous period command,
// gain factor and the operation (run one step or preload the history).
// out_o returns exactly one result item per input item: clamped drive,
// limited error and the doubled sample sum. both are valid/ready channels.
// cfg_we_i/cfg_idx_i/cfg_data_i write the five coefficients; write only
// while the block is idle.
// a run item steps one shared 32x32 multiplier (low 32 bits kept) through
// eight products, gain schedule first, then numerator, scaling and feedback
// terms, and a final step clamps the drive into the output register.
// a preload item goes straight to that final step. in_i.ready is high only
// while idle.
// the output register lets the next item be accepted while a result waits;
// if the receiver stalls, a finished item holds at its last step until the
// output register frees, and the history is updated only then.
// reset (rst_ni low, asynchronous) loads the coefficient defaults, clears
// the output and error history and leaves the block idle with no result.
module voltage_loop_2p2z_compensator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vlc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  vlc_in_if.sink                        in_i,
  vlc_out_if.source                     out_o
);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_e;

  typedef enum logic [3:0] {
    STEP_SCHED = 4'd0,
    STEP_KFF   = 4'd1,
    STEP_N0    = 4'd2,
    STEP_N1    = 4'd3,
    STEP_N2    = 4'd4,
    STEP_SCALE = 4'd5,
    STEP_D1    = 4'd6,
    STEP_D2    = 4'd7,
    STEP_OUT   = 4'd8
  } step_e;

  // coefficients
  logic [31:0] num0_q, num1_q, num2_q;
  logic [15:0] den1_q, den2_q;

  // history
  logic [14:0]       out_hist1_q, out_hist2_q;
  logic signed [7:0] err_hist1_q, err_hist2_q;

  // sequencer and item registers
  state_e            state_q;
  step_e             step_q;
  logic              op_q;
  logic [14:0]       period_q;
  logic [10:0]       gain_q;
  logic [11:0]       vsum_q;
  logic signed [7:0] err_q;
  logic [7:0]        sched_q;
  logic [7:0]        kff_q;
  logic [31:0]       acc_q;

  // output register
  logic              out_valid_q;
  vlc_pkg::vlc_out_t out_data_q;

  logic in_fire;
  logic finish;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign finish      = (state_q == S_BUSY) && (step_q == STEP_OUT) &&
                       (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // sample sum and slew-limited, clamped error at accept
  logic [10:0]        pair_sum;
  logic [11:0]        vsum_d;
  logic signed [13:0] raw_err;
  logic signed [14:0] err_delta;
  logic signed [13:0] hist1_ext;
  logic signed [13:0] slew_err;
  logic signed [7:0]  err_d;

  always_comb begin
    pair_sum  = {1'b0, in_i.data.sample_a} + {1'b0, in_i.data.sample_b};
    vsum_d    = {pair_sum, 1'b0};
    raw_err   = $signed({2'b00, in_i.data.target}) - $signed({2'b00, vsum_d});
    hist1_ext = {{6{err_hist1_q[7]}}, err_hist1_q};
    err_delta = {raw_err[13], raw_err} - {hist1_ext[13], hist1_ext};
    if (err_delta > vlc_pkg::SLEW_TRIP) begin
      slew_err = hist1_ext + vlc_pkg::SLEW_STEP;
    end else if (err_delta < -vlc_pkg::SLEW_TRIP) begin
      slew_err = hist1_ext - vlc_pkg::SLEW_STEP;
    end else begin
      slew_err = raw_err;
    end
    if (slew_err > vlc_pkg::ERR_LIMIT) begin
      err_d = vlc_pkg::ERR_LIMIT[7:0];
    end else if (slew_err < -vlc_pkg::ERR_LIMIT) begin
      err_d = 8'(-vlc_pkg::ERR_LIMIT);
    end else begin
      err_d = slew_err[7:0];
    end
  end

  // shared multiplier operand select
  logic [31:0] mul_a, mul_b, mul_p;

  always_comb begin
    case (step_q)
      STEP_SCHED: begin
        mul_a = {17'd0, period_q};
        mul_b = vlc_pkg::SCHED_MUL;
      end
      STEP_KFF: begin
        mul_a = {24'd0, sched_q};
        mul_b = {21'd0, gain_q};
      end
      STEP_N0: begin
        mul_a = {{24{err_q[7]}}, err_q};
        mul_b = num0_q;
      end
      STEP_N1: begin
        mul_a = {{24{err_hist1_q[7]}}, err_hist1_q};
        mul_b = num1_q;
      end
      STEP_N2: begin
        mul_a = {{24{err_hist2_q[7]}}, err_hist2_q};
        mul_b = num2_q;
      end
      STEP_SCALE: begin
        mul_a = {24'd0, kff_q};
        mul_b = acc_q;
      end
      STEP_D1: begin
        mul_a = {{16{den1_q[15]}}, den1_q};
        mul_b = {17'd0, out_hist1_q};
      end
      STEP_D2: begin
        mul_a = {{16{den2_q[15]}}, den2_q};
        mul_b = {17'd0, out_hist2_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // gain schedule clamp from the first product
  logic [10:0] sched_raw;
  logic [7:0]  sched_d;

  always_comb begin
    sched_raw = mul_p[25:15];
    if (sched_raw <= (vlc_pkg::SCHED_OFS + {3'd0, vlc_pkg::SCHED_LO})) begin
      sched_d = vlc_pkg::SCHED_LO;
    end else if (sched_raw > (vlc_pkg::SCHED_OFS + {3'd0, vlc_pkg::SCHED_HI})) begin
      sched_d = vlc_pkg::SCHED_HI;
    end else begin
      sched_d = 8'(sched_raw - vlc_pkg::SCHED_OFS);
    end
  end

  // final shift and drive clamp
  logic signed [31:0] y_val;
  logic [14:0]        drive_d;

  always_comb begin
    y_val = $signed(acc_q) >>> 13;
    if (y_val > vlc_pkg::DRIVE_MAX) begin
      drive_d = vlc_pkg::DRIVE_MAX[14:0];
    end else if (y_val <= vlc_pkg::DRIVE_MIN) begin
      drive_d = vlc_pkg::DRIVE_MIN[14:0];
    end else begin
      drive_d = y_val[14:0];
    end
  end

  // sequencer, datapath registers, history and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= STEP_SCHED;
      num0_q      <= vlc_pkg::NUM0_RST;
      num1_q      <= vlc_pkg::NUM1_RST;
      num2_q      <= vlc_pkg::NUM2_RST;
      den1_q      <= vlc_pkg::DEN1_RST;
      den2_q      <= vlc_pkg::DEN2_RST;
      out_hist1_q <= '0;
      out_hist2_q <= '0;
      err_hist1_q <= '0;
      err_hist2_q <= '0;
      op_q        <= vlc_pkg::OP_RUN;
      period_q    <= '0;
      gain_q      <= '0;
      vsum_q      <= '0;
      err_q       <= '0;
      sched_q     <= '0;
      kff_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // coefficient writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          vlc_pkg::CFG_NUM0: num0_q <= cfg_data_i;
          vlc_pkg::CFG_NUM1: num1_q <= cfg_data_i;
          vlc_pkg::CFG_NUM2: num2_q <= cfg_data_i;
          vlc_pkg::CFG_DEN1: den1_q <= cfg_data_i[15:0];
          vlc_pkg::CFG_DEN2: den2_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      // new result loaded, or result taken by the receiver
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q  <= S_BUSY;
            op_q     <= in_i.data.operation;
            period_q <= in_i.data.period_command;
            gain_q   <= in_i.data.gain_factor;
            vsum_q   <= vsum_d;
            err_q    <= err_d;
            step_q   <= (in_i.data.operation == vlc_pkg::OP_PRELOAD) ? STEP_OUT
                                                                     : STEP_SCHED;
          end
        end
        S_BUSY: begin
          case (step_q)
            STEP_SCHED: sched_q <= sched_d;
            STEP_KFF:   kff_q   <= mul_p[17:10];
            STEP_N0:    acc_q   <= mul_p;
            STEP_N1:    acc_q   <= acc_q + mul_p;
            STEP_N2:    acc_q   <= acc_q + mul_p;
            STEP_SCALE: acc_q   <= {{7{mul_p[31]}}, mul_p[31:7]};
            STEP_D1:    acc_q   <= acc_q + mul_p;
            STEP_D2:    acc_q   <= acc_q + mul_p;
            default: ;
          endcase
          if (step_q != STEP_OUT) begin
            step_q <= step_e'(step_q + 4'd1);
          end
          // load result and update history once the output register is free
          if (finish) begin
            state_q                  <= S_IDLE;
            out_data_q.voltage_sum   <= vsum_q;
            if (op_q == vlc_pkg::OP_PRELOAD) begin
              out_data_q.drive         <= period_q;
              out_data_q.limited_error <= '0;
              out_hist1_q              <= period_q;
              out_hist2_q              <= period_q;
              err_hist1_q              <= '0;
              err_hist2_q              <= '0;
            end else begin
              out_data_q.drive         <= drive_d;
              out_data_q.limited_error <= err_q;
              out_hist1_q              <= drive_d;
              out_hist2_q              <= out_hist1_q;
              err_hist1_q              <= err_q;
              err_hist2_q              <= err_hist1_q;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // an accepted item makes the block busy in the cycle after its accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("block ready right after accepting an item");

  // the step counter advances by one while a run item is in the multiplier
  a_step_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BUSY && step_q != STEP_OUT) |=> (step_q == $past(step_q) + 4'd1))
    else $error("sequencer skipped a step");

  // limited error stays within its clamp
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.limited_error <= 8'sd100 &&
                     out_data_q.limited_error >= -8'sd100))
    else $error("limited error out of range");

  // a run result with nonzero error carries a clamped drive
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.limited_error != 8'sd0) |->
      (out_data_q.drive >= 15'd2600 && out_data_q.drive <= 15'd25000))
    else $error("drive outside its clamp");

  // a new result is loaded only when the old one was free or taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_data_q)))
    else $error("waiting result overwritten");
`endif

endmodule

>>> verif/tb_top.sv
// self-checking testbench of the voltage loop 2p2z compensator unit
`timescale 1ns / 100ps

module tb_top;

  // compensator constants
  localparam int GS_MUL  = 1101;
  localparam int GS_OFS  = 74;
  localparam int GS_MIN  = 44;
  localparam int GS_MAX  = 128;
  localparam int ERR_TRIP = 100;
  localparam int ERR_SLEW = 50;
  localparam int ERR_MAX  = 100;
  localparam int DRV_MAX  = 25000;
  localparam int DRV_MIN  = 2600;

  // index past the register list, writes to it must be dropped
  localparam logic [vlc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int DRAIN_CYCLES = 16;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [vlc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]                   cfg_data_i;

  vlc_in_if  in_ch ();
  vlc_out_if out_ch ();

  voltage_loop_2p2z_compensator_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // coefficient and history copies of the compensator
  int      coef_n0, coef_n1, coef_n2;
  shortint coef_d1, coef_d2;
  int      y_hist1, y_hist2;
  int      e_hist1, e_hist2;

  vlc_pkg::vlc_in_t  item_q[$];
  vlc_pkg::vlc_out_t comp_res_q[$];
  vlc_pkg::vlc_out_t want_res;
  logic     in_took = 1'b0;
  int       n_pushed = 0;
  int       n_accepted = 0;
  int       n_checked = 0;
  int       n_errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_left = 0;

  // one compensator step on the local state, returns the expected result item
  function automatic vlc_pkg::vlc_out_t comp_step(vlc_pkg::vlc_in_t it);
    vlc_pkg::vlc_out_t res;
    int vsum, sched, kff, err, delta, den_acc, num_acc, scaled, y, drv;
    vsum = 2 * int'(it.sample_a) + 2 * int'(it.sample_b);
    res.voltage_sum = vsum[11:0];
    if (it.operation == vlc_pkg::OP_PRELOAD) begin
      y_hist1 = int'(it.period_command);
      y_hist2 = int'(it.period_command);
      e_hist1 = 0;
      e_hist2 = 0;
      res.drive = it.period_command;
      res.limited_error = '0;
      return res;
    end
    // gain schedule from the previous period command
    sched = ((int'(it.period_command) * GS_MUL) >> 15) - GS_OFS;
    if (sched <= GS_MIN) sched = GS_MIN;
    else if (sched > GS_MAX) sched = GS_MAX;
    kff = (sched * int'(it.gain_factor)) >> 10;
    // error with slew limit and clamp
    err = int'(it.target) - vsum;
    delta = err - e_hist1;
    if (delta > ERR_TRIP) err = e_hist1 + ERR_SLEW;
    else if (delta < -ERR_TRIP) err = e_hist1 - ERR_SLEW;
    if (err > ERR_MAX) err = ERR_MAX;
    else if (err < -ERR_MAX) err = -ERR_MAX;
    // difference equation, all int math wraps at 32 bits
    den_acc = int'(coef_d1) * y_hist1 + int'(coef_d2) * y_hist2;
    num_acc = err * coef_n0 + e_hist1 * coef_n1 + e_hist2 * coef_n2;
    scaled = (kff * num_acc) >>> 7;
    y = (den_acc + scaled) >>> 13;
    if (y > DRV_MAX) drv = DRV_MAX;
    else if (y <= DRV_MIN) drv = DRV_MIN;
    else drv = y;
    y_hist2 = y_hist1;
    y_hist1 = drv;
    e_hist2 = e_hist1;
    e_hist1 = err;
    res.drive = drv[14:0];
    res.limited_error = err[7:0];
    return res;
  endfunction

  // register write on the local copy
  function automatic void coef_write(logic [vlc_pkg::CFG_IDX_W-1:0] idx,
                                     logic [31:0] val);
    case (idx)
      vlc_pkg::CFG_NUM0: coef_n0 = val;
      vlc_pkg::CFG_NUM1: coef_n1 = val;
      vlc_pkg::CFG_NUM2: coef_n2 = val;
      vlc_pkg::CFG_DEN1: coef_d1 = val[15:0];
      vlc_pkg::CFG_DEN2: coef_d2 = val[15:0];
      default: ;
    endcase
  endfunction

  // one register write, block must be idle
  task automatic cfg_write(logic [vlc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    coef_write(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_item(logic op, logic [9:0] a, logic [9:0] b, logic [11:0] tgt,
                           logic [14:0] per, logic [10:0] gain);
    vlc_pkg::vlc_in_t it;
    it.operation      = op;
    it.sample_a       = a;
    it.sample_b       = b;
    it.target         = tgt;
    it.period_command = per;
    it.gain_factor    = gain;
    item_q.push_back(it);
    n_pushed++;
  endtask

  // wait until every item has its result, then let the block settle
  task automatic drain();
    wait (n_checked == n_pushed);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // random items, mostly targets close to the sample sum so the error stays live
  task automatic run_phase(int n_items, int send_pct, int stall_pct);
    logic [9:0]  a, b;
    logic [11:0] tgt;
    logic [14:0] per;
    logic [10:0] gain;
    logic        op;
    int          s;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      a = 10'($urandom_range(1023));
      b = 10'($urandom_range(1023));
      s = 2 * int'(a) + 2 * int'(b);
      if ($urandom_range(99) < 70) s = s + int'($urandom_range(300)) - 150;
      else s = $urandom_range(4095);
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      tgt  = s[11:0];
      per  = ($urandom_range(99) < 50) ? 15'($urandom_range(7000, 2500))
                                       : 15'($urandom_range(32767));
      gain = ($urandom_range(99) < 25) ? 11'd1024 : 11'($urandom_range(2047));
      op   = ($urandom_range(99) < 8) ? vlc_pkg::OP_PRELOAD : vlc_pkg::OP_RUN;
      push_item(op, a, b, tgt, per, gain);
    end
    drain();
  endtask

  // input driver: hold an item until taken, idle at random between items
  always @(negedge clk_i) begin
    if (!in_ch.valid || in_took) begin
      if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.data  <= item_q.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: long hold-off when armed, random stalls otherwise
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on input accept, check on result accept
  always @(posedge clk_i) begin
    in_took <= in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        comp_res_q.push_back(comp_step(in_ch.data));
        n_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (comp_res_q.size() == 0) begin
          $display("%0t: unexpected result, drive %0d error %0d sum %0d", $time,
                   out_ch.data.drive, out_ch.data.limited_error, out_ch.data.voltage_sum);
          n_errors++;
        end else begin
          want_res = comp_res_q.pop_front();
          n_checked++;
          if (out_ch.data.drive !== want_res.drive) begin
            $display("%0t: drive mismatch, expected %0d, actual %0d", $time,
                     want_res.drive, out_ch.data.drive);
            n_errors++;
          end
          if (out_ch.data.limited_error !== want_res.limited_error) begin
            $display("%0t: limited_error mismatch, expected %0d, actual %0d", $time,
                     want_res.limited_error, out_ch.data.limited_error);
            n_errors++;
          end
          if (out_ch.data.voltage_sum !== want_res.voltage_sum) begin
            $display("%0t: voltage_sum mismatch, expected %0d, actual %0d", $time,
                     want_res.voltage_sum, out_ch.data.voltage_sum);
            n_errors++;
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #(2_000_000);
    $display("Verification failed");
    $finish;
  end

  // stimulus
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    coef_n0 = -63962;
    coef_n1 = 79458;
    coef_n2 = -22651;
    coef_d1 = 8435;
    coef_d2 = -243;
    y_hist1 = 0;
    y_hist2 = 0;
    e_hist1 = 0;
    e_hist2 = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed items on reset coefficients
    // all fields at their maximum, preload
    push_item(vlc_pkg::OP_PRELOAD, 10'd1023, 10'd1023, 12'd4095, 15'd32767, 11'd2047);
    // big positive step, slew up, schedule at its low clamp, zero gain
    push_item(vlc_pkg::OP_RUN, 10'd0, 10'd0, 12'd4095, 15'd0, 11'd0);
    // slew up again, schedule at its high clamp, full gain
    push_item(vlc_pkg::OP_RUN, 10'd0, 10'd0, 12'd4095, 15'd32767, 11'd2047);
    // big negative steps walk the error down into the negative clamp
    push_item(vlc_pkg::OP_RUN, 10'd1023, 10'd1023, 12'd0, 15'd5000, 11'd1024);
    push_item(vlc_pkg::OP_RUN, 10'd1023, 10'd1023, 12'd0, 15'd5000, 11'd1024);
    push_item(vlc_pkg::OP_RUN, 10'd1023, 10'd1023, 12'd0, 15'd5000, 11'd1024);
    push_item(vlc_pkg::OP_RUN, 10'd1023, 10'd1023, 12'd0, 15'd5000, 11'd1024);
    push_item(vlc_pkg::OP_RUN, 10'd1023, 10'd1023, 12'd0, 15'd5000, 11'd1024);
    // all-zero preload clears the history
    push_item(vlc_pkg::OP_PRELOAD, 10'd0, 10'd0, 12'd0, 15'd0, 11'd0);
    // step of exactly the slew trip, no slew, schedule right at its low bound
    push_item(vlc_pkg::OP_RUN, 10'd25, 10'd25, 12'd200, 15'd3512, 11'd1024);
    // small step over the error clamp, schedule right at its high bound
    push_item(vlc_pkg::OP_RUN, 10'd25, 10'd25, 12'd250, 15'd6012, 11'd1024);
    // step down of exactly the trip, schedule just under its low bound
    push_item(vlc_pkg::OP_RUN, 10'd25, 10'd25, 12'd100, 15'd3511, 11'd1024);
    // step down one past the trip, schedule just under its high bound
    push_item(vlc_pkg::OP_RUN, 10'd51, 10'd0, 12'd1, 15'd6011, 11'd1024);
    push_item(vlc_pkg::OP_RUN, 10'd0, 10'd0, 12'd0, 15'd4000, 11'd1024);
    // high history drives the output into its upper clamp
    push_item(vlc_pkg::OP_PRELOAD, 10'd512, 10'd0, 12'd2048, 15'd30000, 11'd1024);
    push_item(vlc_pkg::OP_RUN, 10'd512, 10'd0, 12'd1024, 15'd30000, 11'd1024);
    // drive just over the lower clamp
    push_item(vlc_pkg::OP_PRELOAD, 10'd100, 10'd100, 12'd400, 15'd2700, 11'd1024);
    push_item(vlc_pkg::OP_RUN, 10'd100, 10'd100, 12'd400, 15'd2700, 11'd1024);
    // drive right at the lower clamp
    push_item(vlc_pkg::OP_PRELOAD, 10'd300, 10'd200, 12'd1000, 15'd2600, 11'd1024);
    push_item(vlc_pkg::OP_RUN, 10'd300, 10'd200, 12'd1000, 15'd2600, 11'd1024);
    push_item(vlc_pkg::OP_RUN, 10'd1023, 10'd0, 12'd4095, 15'd16000, 11'd2047);
    push_item(vlc_pkg::OP_PRELOAD, 10'd1, 10'd1, 12'd1, 15'd1, 11'd1);
    push_item(vlc_pkg::OP_RUN, 10'd682, 10'd341, 12'd2730, 15'd21845, 11'd1365);
    drain();

    // reset coefficients, no idling
    run_phase(100, 0, 0);

    // moderate random coefficients, sender idle
    cfg_write(vlc_pkg::CFG_NUM0, int'($urandom_range(400000)) - 200000);
    cfg_write(vlc_pkg::CFG_NUM1, int'($urandom_range(400000)) - 200000);
    cfg_write(vlc_pkg::CFG_NUM2, int'($urandom_range(400000)) - 200000);
    cfg_write(vlc_pkg::CFG_DEN1, $urandom_range(12000));
    cfg_write(vlc_pkg::CFG_DEN2, int'($urandom_range(2000)) - 2000);
    run_phase(100, 57, 0);

    // extremes, receiver stalling
    cfg_write(vlc_pkg::CFG_NUM0, 32'h7FFF_FFFF);
    cfg_write(vlc_pkg::CFG_NUM1, 32'h8000_0000);
    cfg_write(vlc_pkg::CFG_NUM2, 32'h7FFF_FFFF);
    cfg_write(vlc_pkg::CFG_DEN1, 32'h0000_7FFF);
    cfg_write(vlc_pkg::CFG_DEN2, 32'hFFFF_8000);
    run_phase(100, 0, 57);

    // opposite extremes, spare index must not disturb anything, both sides idle
    cfg_write(vlc_pkg::CFG_NUM0, 32'h8000_0000);
    cfg_write(vlc_pkg::CFG_NUM1, 32'h7FFF_FFFF);
    cfg_write(vlc_pkg::CFG_NUM2, 32'h8000_0000);
    cfg_write(vlc_pkg::CFG_DEN1, 32'h0000_8000);
    cfg_write(vlc_pkg::CFG_DEN2, 32'h0000_7FFF);
    cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
    run_phase(100, 16, 16);

    // back to defaults, then a long receiver hold-off while items keep coming
    cfg_write(vlc_pkg::CFG_NUM0, -63962);
    cfg_write(vlc_pkg::CFG_NUM1, 79458);
    cfg_write(vlc_pkg::CFG_NUM2, -22651);
    cfg_write(vlc_pkg::CFG_DEN1, 8435);
    cfg_write(vlc_pkg::CFG_DEN2, -243);
    @(posedge clk_i);
    hold_left = 300;
    run_phase(40, 0, 0);

    // fully random register data, upper bits of the short registers too
    cfg_write(vlc_pkg::CFG_NUM0, $urandom);
    cfg_write(vlc_pkg::CFG_NUM1, $urandom);
    cfg_write(vlc_pkg::CFG_NUM2, $urandom);
    cfg_write(vlc_pkg::CFG_DEN1, $urandom);
    cfg_write(vlc_pkg::CFG_DEN2, $urandom);
    cfg_write(CFG_SPARE, $urandom);
    run_phase(90, 16, 16);

    if (n_errors == 0 && n_checked == n_pushed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
